>>> hw/rtl/ort_pkg.sv
`default_nettype none
package ort_pkg;
    localparam int TableDepth = 16;
    localparam int SlotW = $clog2(TableDepth);
    localparam int DlW = 48;
    // entry word: netfn 6, lun 2, seq 6, opcode 8, tag 8, retries 4
    localparam int EntW = 34;
    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_RESP = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] EV_SEND  = 2'd0;
    localparam logic [1:0] EV_FAIL  = 2'd1;
    localparam logic [1:0] EV_MATCH = 2'd2;
    localparam logic [0:0] REG_TIMEOUT = 1'd0;
    localparam logic [0:0] REG_LIMIT   = 1'd1;

    typedef struct packed {
        logic [5:0] nf;
        logic [1:0] lun;
        logic [5:0] seq;
        logic [7:0] op;
        logic [7:0] tag;
        logic [3:0] retries;
    } t_entry;

    function automatic logic [DlW-1:0] deadline_from(input logic [DlW-1:0] now,
                                                     input logic [31:0] tmo);
        logic [DlW:0] d;
        d = {1'b0, now} + {{(DlW-31){1'b0}}, tmo};
        return d[DlW] ? {DlW{1'b1}} : d[DlW-1:0];
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/ort_ram.sv
`default_nettype none
module ort_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(Depth)-1:0] i_waddr,
    input  wire [Width-1:0]         i_wdata,
    input  wire [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]        o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/outstanding_request_tracker.sv
`default_nettype none
// Add: the input stalls while the result word goes via S_DRAIN to the output
// register. Response and tick walk valid entries in deadline order, each step a
// scan of all deadlines (S_WTDL), entry read (S_RDENT) and action (S_ACT), with
// S_EMIT when a tick word queues behind another; the input stalls until the walk
// ends, and output stalls lengthen it. Synchronous active-low reset clears valid
// bits, sequence and control, sets 250000 us and 6 retries; memory is not cleared.
module outstanding_request_tracker import ort_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_command,
    input  wire  [5:0]  i_net_function,
    input  wire  [1:0]  i_responder_lun,
    input  wire  [1:0]  i_requester_lun,
    input  wire  [5:0]  i_sequence_req,
    input  wire  [7:0]  i_opcode,
    input  wire  [7:0]  i_client_tag,
    input  wire  [47:0] i_now_us,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [1:0]  o_event_res,
    output logic [5:0]  o_out_net_function,
    output logic [1:0]  o_out_lun,
    output logic [5:0]  o_out_sequence,
    output logic [7:0]  o_out_opcode,
    output logic [7:0]  o_out_tag,
    output logic        o_last,
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIND  = 7'b0000010,
        S_WTDL  = 7'b0000100,
        S_RDENT = 7'b0001000,
        S_ACT   = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_DRAIN = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [31:0] r_tmo;
    logic [3:0]  r_lim;
    logic [TableDepth-1:0] r_valid, n_valid;
    logic [TableDepth-1:0] r_done, n_done;   // visited by this walk, or invalid when it began
    logic [5:0]  r_seq, n_seq;
    logic [1:0]  r_cmd;
    logic [5:0]  r_nf;
    logic [1:0]  r_rsl, r_rql;
    logic [5:0]  r_sq;
    logic [7:0]  r_op;
    logic [47:0] r_now;
    logic [SlotW-1:0] r_ptr, n_ptr;         // scan pointer
    logic [SlotW-1:0] r_best, n_best;
    logic [47:0] r_bdl, n_bdl;
    logic        r_bok, n_bok;
    // hold stage: a word whose last flag is not yet known
    logic        r_hv, n_hv;
    logic [1:0]  r_hev, n_hev;
    t_entry      r_hent, n_hent;
    // word waiting behind the hold stage
    logic [1:0]  r_wev, n_wev;
    t_entry      r_went, n_went;
    // output register
    logic        r_ov, n_ov;
    logic [1:0]  r_oev, n_oev;
    t_entry      r_oent, n_oent;
    logic        r_olast, n_olast;

    logic        dl_we, en_we;
    logic [SlotW-1:0] dl_wa, en_wa, dl_ra, en_ra;
    logic [47:0] dl_wd, dl_rd;
    t_entry      en_wd, en_rd;
    logic [EntW-1:0] en_rd_raw;
    logic [SlotW-1:0] free_slot;
    logic        any_free, out_free, matched;

    ort_ram #(.Width(DlW), .Depth(TableDepth)) u_dl (
        .i_clk(i_clk), .i_we(dl_we), .i_waddr(dl_wa), .i_wdata(dl_wd),
        .i_raddr(dl_ra), .o_rdata(dl_rd));
    ort_ram #(.Width(EntW), .Depth(TableDepth)) u_ent (
        .i_clk(i_clk), .i_we(en_we), .i_waddr(en_wa), .i_wdata(en_wd),
        .i_raddr(en_ra), .o_rdata(en_rd_raw));
    assign en_rd = t_entry'(en_rd_raw);

    always_comb begin
        free_slot = '0;
        any_free = 1'b0;
        for (int i = TableDepth - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = SlotW'(i);
                any_free = 1'b1;
            end
        end
    end

    assign out_free = !r_ov || !i_stall;
    assign o_stall = (r_state != S_IDLE);
    assign matched = ((en_rd.nf | 6'd1) == r_nf) && en_rd.lun == r_rql &&
                     en_rd.lun == r_rsl && en_rd.seq == r_sq && en_rd.op == r_op;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_done = r_done;
        n_seq = r_seq;
        n_ptr = r_ptr;
        n_best = r_best;
        n_bdl = r_bdl;
        n_bok = r_bok;
        n_hv = r_hv;
        n_hev = r_hev;
        n_hent = r_hent;
        n_wev = r_wev;
        n_went = r_went;
        n_ov = r_ov && i_stall;
        n_oev = r_oev;
        n_oent = r_oent;
        n_olast = r_olast;
        dl_we = 1'b0;
        en_we = 1'b0;
        dl_wa = free_slot;
        en_wa = free_slot;
        dl_wd = deadline_from(i_now_us, r_tmo);
        en_wd = '{nf: i_net_function, lun: i_responder_lun, seq: r_seq,
                  op: i_opcode, tag: i_client_tag, retries: r_lim};
        dl_ra = r_ptr;
        en_ra = r_best;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_command == CMD_ADD) begin
                        n_hv = 1'b1;
                        n_hev = any_free ? EV_SEND : EV_FAIL;
                        n_hent = en_wd;
                        n_state = S_DRAIN;
                        if (any_free) begin
                            dl_we = 1'b1;
                            en_we = 1'b1;
                            n_valid[free_slot] = 1'b1;
                            n_seq = r_seq + 6'd1;
                        end
                    end else if (i_command inside {CMD_RESP, CMD_TICK}) begin
                        n_done = ~r_valid;
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                n_ptr = '0;
                n_bok = 1'b0;
                dl_ra = '0;
                if (&r_done) begin
                    n_state = r_hv ? S_DRAIN : S_IDLE;
                end else begin
                    n_state = S_WTDL;
                end
            end
            S_WTDL: begin
                // min search over unvisited valid slots, one per cycle
                if (!r_done[r_ptr] && (!r_bok || dl_rd < r_bdl)) begin
                    n_best = r_ptr;
                    n_bdl = dl_rd;
                    n_bok = 1'b1;
                end
                if (r_ptr == SlotW'(TableDepth - 1)) begin
                    n_state = S_RDENT;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                    dl_ra = n_ptr;
                end
            end
            S_RDENT: begin
                n_state = S_ACT;
            end
            S_ACT: begin
                n_done[r_best] = 1'b1;
                n_state = S_FIND;
                if (r_cmd == CMD_RESP) begin
                    if (matched) begin
                        n_valid[r_best] = 1'b0;
                        n_hv = 1'b1;
                        n_hev = EV_MATCH;
                        n_hent = en_rd;
                        n_state = S_DRAIN;
                    end
                end else if (en_rd.retries == 4'd0 || r_bdl <= r_now) begin
                    if (en_rd.retries == 4'd0) begin
                        n_wev = EV_FAIL;
                        n_valid[r_best] = 1'b0;
                    end else begin
                        n_wev = EV_SEND;
                        en_we = 1'b1;
                        en_wa = r_best;
                        en_wd = en_rd;
                        en_wd.retries = en_rd.retries - 4'd1;
                        dl_we = 1'b1;
                        dl_wa = r_best;
                        dl_wd = deadline_from(r_now, r_tmo);
                    end
                    n_went = en_rd;
                    if (r_hv) begin
                        n_state = S_EMIT;
                    end else begin
                        n_hv = 1'b1;
                        n_hev = n_wev;
                        n_hent = en_rd;
                    end
                end else begin
                    // walk stops here; the held word is the last one
                    n_state = r_hv ? S_DRAIN : S_IDLE;
                end
            end
            S_EMIT: begin
                // a later word exists, so the held word is not last
                if (out_free) begin
                    n_ov = 1'b1;
                    n_oev = r_hev;
                    n_oent = r_hent;
                    n_olast = 1'b0;
                    n_hev = r_wev;
                    n_hent = r_went;
                    n_state = S_FIND;
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_oev = r_hev;
                    n_oent = r_hent;
                    n_olast = 1'b1;
                    n_hv = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_seq <= '0;
            r_tmo <= 32'd250000;
            r_lim <= 4'd6;
            r_ov <= 1'b0;
            r_hv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_seq <= n_seq;
            r_ov <= n_ov;
            r_hv <= n_hv;
            if (i_cfg_we && i_cfg_index == REG_TIMEOUT) begin
                r_tmo <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == REG_LIMIT) begin
                r_lim <= i_cfg_data[3:0];
            end
        end
        if (r_state == S_IDLE) begin
            r_cmd <= i_command;
            r_nf <= i_net_function;
            r_rsl <= i_responder_lun;
            r_rql <= i_requester_lun;
            r_sq <= i_sequence_req;
            r_op <= i_opcode;
            r_now <= i_now_us;
        end
        r_done <= n_done;
        r_ptr <= n_ptr;
        r_best <= n_best;
        r_bdl <= n_bdl;
        r_bok <= n_bok;
        r_hev <= n_hev;
        r_hent <= n_hent;
        r_wev <= n_wev;
        r_went <= n_went;
        r_oev <= n_oev;
        r_oent <= n_oent;
        r_olast <= n_olast;
    end

    assign o_valid = r_ov;
    assign o_event_res = r_oev;
    assign o_out_net_function = r_oent.nf;
    assign o_out_lun = r_oent.lun;
    assign o_out_sequence = r_oent.seq;
    assign o_out_opcode = r_oent.op;
    assign o_out_tag = r_oent.tag;
    assign o_last = r_olast;
endmodule
`default_nettype wire

>>> hw/rtl/ort_checker.sv
`default_nettype none
module ort_checker import ort_pkg::*; (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       o_stall,
    input wire       o_valid,
    input wire       i_stall,
    input wire [1:0] o_event_res,
    input wire       o_last
);
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_event_res) && $stable(o_last))
        else $error("output word dropped under stall");
    ap_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_event_res <= EV_MATCH)
        else $error("bad event code");
    ap_match_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res == EV_MATCH |-> o_last)
        else $error("match not final");
    ap_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
    ap_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({i_valid, o_stall, o_valid}))
        else $error("handshake unknown");
endmodule

bind outstanding_request_tracker ort_checker u_ort_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_event_res(o_event_res),
    .o_last(o_last));
`default_nettype wire
